@@ rtl/rdisc_pkg.sv @@
// Package for the radial gradient disc pixel block.
// Holds coordinate and datapath widths, register addresses and the stage record.
// No dependencies.
`default_nettype none
package rdisc_pkg;

    localparam int COORD_BITS = 12;

    // configuration register widths and reset values
    localparam int DIM_W = 13;
    localparam int RAD_W = 11;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd1600;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd1200;
    localparam logic [RAD_W-1:0] RADIUS_RST = 11'd400;

    // doubled offsets: wide enough for 2*coord and for the frame dimension
    localparam int DBL_W = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;
    localparam int DX_W  = DBL_W + 1;
    localparam int SQ_W  = 2 * DX_W;
    localparam int SUM_W = SQ_W + 1;

    // 4*radius^2 and the scaled square inside the disc
    localparam int LIM_W = 2 * RAD_W + 2;
    localparam int M_W   = LIM_W + 16;
    localparam logic [15:0] GREY_SCALE = 16'd65025;   // 255^2

    // grey search
    localparam int G_W  = 8;
    localparam int Q_W  = LIM_W + G_W;
    localparam int TR_W = M_W + 2;

    // register addresses (byte address / 4)
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    // record passed from geometry stages to the grey search
    typedef struct packed {
        logic           in_disc;
        logic [M_W-1:0] m;
    } t_geom;

endpackage
`default_nettype wire

@@ rtl/rdisc_geom.sv @@
// Geometry stages of the disc block: offsets, squares, distance test, scaling.
// Four register stages; depends on rdisc_pkg.
`default_nettype none
module rdisc_geom
    import rdisc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [COORD_BITS-1:0] i_pixel_x,
    input  wire logic [COORD_BITS-1:0] i_pixel_y,
    input  wire logic [DIM_W-1:0]      i_width,
    input  wire logic [DIM_W-1:0]      i_height,
    input  wire logic [LIM_W-1:0]      i_lim,
    output logic                       o_valid,
    output t_geom                      o_geom
);

    logic [3:0] r_v;
    logic signed [DX_W-1:0] r_dx, r_dy;
    logic [SQ_W-1:0]  r_sx, r_sy;
    logic [SUM_W-1:0] r_s;
    logic             r_in3;
    t_geom            r_g4;
    logic [SUM_W-1:0] n_s;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    assign n_s = SUM_W'(r_sx) + SUM_W'(r_sy);

    // datapath
    always_ff @(posedge i_clk) begin
        // stage 1: doubled offsets from the centre
        r_dx <= $signed({1'b0, DBL_W'({i_pixel_x, 1'b0})}) - $signed({1'b0, DBL_W'(i_width)});
        r_dy <= $signed({1'b0, DBL_W'({i_pixel_y, 1'b0})}) - $signed({1'b0, DBL_W'(i_height)});
        // stage 2: squares
        r_sx <= SQ_W'(r_dx * r_dx);
        r_sy <= SQ_W'(r_dy * r_dy);
        // stage 3: distance test
        r_s   <= n_s;
        r_in3 <= (n_s <= SUM_W'(i_lim));
        // stage 4: scale by 255^2, only meaningful inside
        r_g4.in_disc <= r_in3;
        r_g4.m       <= r_in3 ? M_W'(r_s[LIM_W-1:0] * GREY_SCALE) : '0;
    end

    assign o_valid = r_v[3];
    assign o_geom  = r_g4;

endmodule
`default_nettype wire

@@ rtl/rdisc_grey.sv @@
// Grey search of the disc block: largest g with (g*2r)^2 <= 65025*S.
// One bit a stage, eight stages of shift and add; depends on rdisc_pkg.
`default_nettype none
module rdisc_grey
    import rdisc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire t_geom            i_geom,
    input  wire logic [LIM_W-1:0] i_lim,
    output logic                  o_valid,
    output logic                  o_inside,
    output logic [G_W-1:0]        o_grey
);

    // stage k holds g, g^2*lim (p) and g*lim (q)
    logic            r_v  [1:G_W];
    logic [TR_W-1:0] r_p  [1:G_W];
    logic [Q_W-1:0]  r_q  [1:G_W];
    logic [G_W-1:0]  r_g  [1:G_W];
    logic [M_W-1:0]  r_m  [1:G_W];
    logic            r_in [1:G_W];

    for (genvar i = 0; i < G_W; i++) begin : g_stage
        localparam int K = G_W - 1 - i;
        logic            w_v;
        logic [TR_W-1:0] w_p;
        logic [Q_W-1:0]  w_q;
        logic [G_W-1:0]  w_g;
        logic [M_W-1:0]  w_m;
        logic            w_in;
        logic [TR_W-1:0] n_trial;
        logic            n_take;

        // stage inputs: the geometry record feeds the first stage
        if (i == 0) begin : g_first
            assign w_v  = i_valid;
            assign w_p  = '0;
            assign w_q  = '0;
            assign w_g  = '0;
            assign w_m  = i_geom.m;
            assign w_in = i_geom.in_disc;
        end else begin : g_next
            assign w_v  = r_v[i];
            assign w_p  = r_p[i];
            assign w_q  = r_q[i];
            assign w_g  = r_g[i];
            assign w_m  = r_m[i];
            assign w_in = r_in[i];
        end

        // (g+2^K)^2*lim = p + q*2^(K+1) + lim*4^K
        assign n_trial = w_p + (TR_W'(w_q) << (K + 1)) + (TR_W'(i_lim) << (2 * K));
        assign n_take  = (n_trial <= TR_W'(w_m));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_m[i+1]  <= w_m;
            r_in[i+1] <= w_in;
            if (n_take) begin
                r_p[i+1] <= n_trial;
                r_q[i+1] <= w_q + (Q_W'(i_lim) << K);
                r_g[i+1] <= w_g | G_W'(1 << K);
            end else begin
                r_p[i+1] <= w_p;
                r_q[i+1] <= w_q;
                r_g[i+1] <= w_g;
            end
        end
    end

    assign o_valid  = r_v[G_W];
    assign o_inside = r_in[G_W];
    assign o_grey   = r_g[G_W];

endmodule
`default_nettype wire

@@ rtl/radial_gradient_disc_pixel.sv @@
// Top level of the radial gradient disc pixel block: APB registers and pipeline.
// Instantiates rdisc_geom and rdisc_grey; depends on rdisc_pkg.
//
// Use: raise start with a pixel coordinate on i_pixel_x / i_pixel_y. busy is
// always low, so one request is taken every clock. The result shows on
// o_grey_level / o_inside_disc for one cycle, marked by o_valid, after four
// geometry stages (offset, square, sum and compare, scale by 255^2) and
// eight grey search stages, one grey bit each. Throughput is one pixel per
// clock.
// Registers on APB: frame_width at 0x0, frame_height at 0x4, disc_radius at
// 0x8. Write them only while no pixel is in flight; 4*radius^2 is registered
// in the cycle after a radius write. pready is always high.
// Reset (synchronous, active low) clears the pipeline valid bits and loads
// the register reset values. The receiver cannot stall: results are shown
// once and must be taken in that cycle.
`default_nettype none
module radial_gradient_disc_pixel
    import rdisc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [COORD_BITS-1:0] i_pixel_x,
    input  wire logic [COORD_BITS-1:0] i_pixel_y,
    output logic                       o_valid,
    output logic [G_W-1:0]             o_grey_level,
    output logic                       o_inside_disc,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [DIM_W-1:0] r_width, r_height;
    logic [RAD_W-1:0] r_radius;
    logic [LIM_W-1:0] r_lim;
    logic             w_wr;
    logic             w_geom_valid, w_grey_valid, w_inside;
    logic [G_W-1:0]   w_grey;
    t_geom            w_geom;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_radius <= RADIUS_RST;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                REG_RADIUS: r_radius <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // 4*radius^2, follows the radius register
    always_ff @(posedge i_clk) begin
        r_lim <= {(2 * RAD_W)'(r_radius * r_radius), 2'b00};
    end

    // read back
    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            REG_RADIUS: prdata = 32'(r_radius);
            default:    prdata = '0;
        endcase
    end

    rdisc_geom u_geom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start && !busy),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_lim     (r_lim),
        .o_valid   (w_geom_valid),
        .o_geom    (w_geom)
    );

    rdisc_grey u_grey (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_geom_valid),
        .i_geom   (w_geom),
        .i_lim    (r_lim),
        .o_valid  (w_grey_valid),
        .o_inside (w_inside),
        .o_grey   (w_grey)
    );

    // zero radius gives no gradient
    assign o_valid       = w_grey_valid;
    assign o_inside_disc = w_inside;
    assign o_grey_level  = (r_radius == '0) ? '0 : w_grey;

    a_out_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_inside_disc |-> o_grey_level == '0)
        else $error("grey level nonzero outside the disc");

    a_search_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_geom_valid, G_W))
        else $error("result without matching geometry request");

    a_geom_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_geom_valid |-> $past(start, 4))
        else $error("geometry stage valid without a request");

endmodule
`default_nettype wire

@@ verif/rdisc_checker.sv @@
// Checker for the radial gradient disc pixel block: follows APB writes and pixel
// requests, predicts grey level and inside flag, and compares the result strobes.
// Depends on rdisc_pkg.
`timescale 1ns / 1ps
module rdisc_checker
    import rdisc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_busy,
    input  wire logic [COORD_BITS-1:0] i_pixel_x,
    input  wire logic [COORD_BITS-1:0] i_pixel_y,
    input  wire logic                  i_valid,
    input  wire logic [G_W-1:0]        i_grey_level,
    input  wire logic                  i_inside_disc,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic                  i_pready,
    input  wire logic [ADDR_W-1:0]     i_paddr,
    input  wire logic [31:0]           i_pwdata,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_results
);

    typedef struct packed {
        logic [G_W-1:0] grey;
        logic           in_disc;
    } t_shade;

    t_shade                shade_q[$];
    logic [DIM_W-1:0]      width_r;
    logic [DIM_W-1:0]      height_r;
    logic [RAD_W-1:0]      radius_r;
    int                    err_cnt;

    // floor of the square root, bit by bit
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_shade shade_of(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
        t_shade          res;
        longint          dx;
        longint          dy;
        longint unsigned s;
        longint unsigned lim;
        dx  = 2 * longint'(px) - longint'(width_r);
        dy  = 2 * longint'(py) - longint'(height_r);
        s   = longint'(dx * dx + dy * dy);
        lim = 4 * longint'(radius_r) * longint'(radius_r);
        res.in_disc = (s <= lim);
        res.grey    = '0;
        if (res.in_disc && radius_r != 0)
            res.grey = G_W'(root_floor(64'd65025 * s) / (2 * longint'(radius_r)));
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_cnt++;
    endtask

    // register shadow, request prediction and result compare
    always @(posedge i_clk) begin
        t_shade exp_s;
        if (!i_rst_n) begin
            width_r   <= WIDTH_RST;
            height_r  <= HEIGHT_RST;
            radius_r  <= RADIUS_RST;
            shade_q.delete();
            err_cnt   = 0;
            o_results <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_WIDTH:  width_r  <= i_pwdata[DIM_W-1:0];
                    REG_HEIGHT: height_r <= i_pwdata[DIM_W-1:0];
                    REG_RADIUS: radius_r <= i_pwdata[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                shade_q.push_back(shade_of(i_pixel_x, i_pixel_y));
            if (i_valid) begin
                o_results <= o_results + 1;
                if (shade_q.size() == 0) begin
                    report_mismatch("result with no request pending");
                end else begin
                    exp_s = shade_q.pop_front();
                    if (i_grey_level !== exp_s.grey)
                        report_mismatch($sformatf("grey %0d, expected %0d",
                                                  i_grey_level, exp_s.grey));
                    if (i_inside_disc !== exp_s.in_disc)
                        report_mismatch($sformatf("inside %0b, expected %0b",
                                                  i_inside_disc, exp_s.in_disc));
                end
            end
        end
    end

    assign o_errors  = err_cnt;
    assign o_pending = shade_q.size();

endmodule

@@ verif/testbench.sv @@
// Top of the disc pixel testbench: clock, reset, APB setup and pixel stimulus.
// Depends on rdisc_pkg, radial_gradient_disc_pixel and rdisc_checker.
`timescale 1ns / 1ps
module testbench
    import rdisc_pkg::*;
();

    localparam int LIMIT = 400000;
    // unmapped register slot
    localparam logic [1:0] REG_NONE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [COORD_BITS-1:0] i_pixel_x = '0;
    logic [COORD_BITS-1:0] i_pixel_y = '0;
    logic                  o_valid;
    logic [G_W-1:0]        o_grey_level;
    logic                  o_inside_disc;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    int                    errors;
    int                    pending;
    int                    results;
    int                    cycles = 0;
    int                    sent = 0;
    int                    cur_w = 1600;
    int                    cur_h = 1200;
    int                    cur_r = 400;

    always #2 i_clk = ~i_clk;

    radial_gradient_disc_pixel u_top (
        .i_clk, .i_rst_n, .start, .busy, .i_pixel_x, .i_pixel_y,
        .o_valid, .o_grey_level, .o_inside_disc,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    rdisc_checker u_chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy),
        .i_pixel_x, .i_pixel_y, .i_valid(o_valid),
        .i_grey_level(o_grey_level), .i_inside_disc(o_inside_disc),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // one pixel request; optional idle cycles in front of it
    task automatic send_pixel(int x, int y, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_pixel_x <= x[COORD_BITS-1:0];
        i_pixel_y <= y[COORD_BITS-1:0];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    // stop requesting and wait for the pipeline to drain
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(int w, int h, int r, logic [31:0] junk);
        drain();
        apb_write(REG_WIDTH, {junk[31:13], w[12:0]});
        apb_write(REG_HEIGHT, {junk[31:13], h[12:0]});
        apb_write(REG_RADIUS, {junk[31:11], r[10:0]});
        // index 3 is not a register; the write must change nothing
        apb_write(REG_NONE, $urandom());
        cur_w = w % 8192;
        cur_h = h % 8192;
        cur_r = r % 2048;
        repeat (3) @(posedge i_clk);
    endtask

    // centre, rim on each axis, just past the rim, then random pixels
    task automatic run_phase(int count, int idle_pct);
        int cx;
        int cy;
        int span;
        cx = cur_w / 2;
        cy = cur_h / 2;
        send_pixel(cx, cy, idle_pct);
        send_pixel(cx + cur_r, cy, idle_pct);
        send_pixel(cx, cy - cur_r, idle_pct);
        send_pixel(cx + cur_r + 1, cy, idle_pct);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                // hold off until every pending result has come back
                start <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if ($urandom_range(99) < 70) begin
                span = cur_r + 2;
                send_pixel(cx + $urandom_range(2 * span) - span,
                           cy + $urandom_range(2 * span) - span, idle_pct);
            end else begin
                send_pixel($urandom(), $urandom(), idle_pct);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // corners of the coordinate range under reset settings
        send_pixel(0, 0, 0);
        send_pixel(4095, 4095, 0);
        send_pixel(4095, 0, 0);
        send_pixel(0, 4095, 0);
        run_phase(170, 15);
        set_frame(4096, 4096, 2047, 32'h0);
        run_phase(170, 15);
        set_frame(2, 2, 0, 32'hFFFF_FFFF);
        run_phase(170, 67);
        set_frame(1, 1, 1, 32'h0);
        run_phase(170, 67);
        set_frame(640, 481, 160, 32'hA5A5_A5A5);
        run_phase(170, 67);
        set_frame(0, 0, 5, 32'h0);
        run_phase(170, 0);
        set_frame(8191, 333, 1500, 32'h5A5A_5A5A);
        run_phase(170, 0);
        drain();
        $display("%0d pixel requests over 7 register settings, %0d results checked",
                 sent, results);
        $display("covered zero and full radius, zero and odd frame sizes, off-frame pixels");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rdisc_pkg.sv
rtl/rdisc_geom.sv
rtl/rdisc_grey.sv
rtl/radial_gradient_disc_pixel.sv
verif/rdisc_checker.sv
verif/testbench.sv
